@@ src/rphv_pkg.sv @@
package rphv_pkg;

    // Verdict codes, in the order the checks are made
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT      = 3'd1,
        ST_BAD_VER    = 3'd2,
        ST_SHORT_HDR  = 3'd3,
        ST_SHORT_EXT  = 3'd4,
        ST_PAD_EMPTY  = 3'd5,
        ST_PAD_ZERO   = 3'd6,
        ST_PAD_LONG   = 3'd7
    } status_t;

    localparam logic [1:0]  RTP_VERSION    = 2'd2;
    localparam logic [15:0] MIN_PKT_BYTES  = 16'd12;
    localparam logic [6:0]  FIXED_HDR      = 7'd12;
    localparam logic [6:0]  EXT_HDR_BYTES  = 7'd4;
    localparam int          TDATA_IN_W     = 8;
    localparam int          TDATA_OUT_W    = 40;

    // Header fields and packet size as seen after the current byte
    typedef struct packed {
        logic        valid;
        logic        last;
        logic [7:0]  data_byte;
        logic [15:0] size;
        logic [1:0]  version;
        logic        padding;
        logic        extension;
        logic [3:0]  csrc_count;
        logic [15:0] ext_words;
    } hdr_info_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] payload_offset;
        logic [15:0] payload_length;
    } verdict_t;

endpackage

@@ src/rphv_track.sv @@
module rphv_track import rphv_pkg::*; #(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  logic [7:0]  data_byte,
    input  logic        end_of_packet,
    input  logic        advance,
    output hdr_info_t   info
);

    localparam logic [15:0] MaxBytes = 16'(MAX_PACKET_BYTES);

    logic        in_valid_reg;
    logic        in_last_reg;
    logic [7:0]  in_data_reg;
    logic [15:0] byte_index_reg, byte_index_next;
    logic [1:0]  version_reg, version_next;
    logic        padding_reg, padding_next;
    logic        extension_reg, extension_next;
    logic [3:0]  csrc_reg, csrc_next;
    logic [15:0] ext_words_reg, ext_words_next;

    logic        in_range;
    logic [15:0] hs_cur;
    logic [15:0] size;

    // Hold the accepted byte until it is processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (load) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            in_data_reg <= data_byte;
            in_last_reg <= end_of_packet;
        end
    end

    // Capture header fields at their byte positions
    always_comb begin
        in_range        = byte_index_reg < MaxBytes;
        hs_cur          = {9'd0, FIXED_HDR + {1'b0, csrc_reg, 2'b00}};
        size            = in_range ? byte_index_reg + 16'd1 : MaxBytes;
        version_next    = version_reg;
        padding_next    = padding_reg;
        extension_next  = extension_reg;
        csrc_next       = csrc_reg;
        ext_words_next  = ext_words_reg;
        if (in_range) begin
            if (byte_index_reg == 16'd0) begin
                version_next   = in_data_reg[7:6];
                padding_next   = in_data_reg[5];
                extension_next = in_data_reg[4];
                csrc_next      = in_data_reg[3:0];
                ext_words_next = 16'd0;
            end else if (extension_reg) begin
                if (byte_index_reg == hs_cur + 16'd2) begin
                    ext_words_next[15:8] = in_data_reg;
                end else if (byte_index_reg == hs_cur + 16'd3) begin
                    ext_words_next[7:0] = in_data_reg;
                end
            end
        end
        byte_index_next = in_last_reg ? 16'd0 : size;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg <= 16'd0;
            version_reg    <= 2'd0;
            padding_reg    <= 1'b0;
            extension_reg  <= 1'b0;
            csrc_reg       <= 4'd0;
            ext_words_reg  <= 16'd0;
        end else if (advance) begin
            byte_index_reg <= byte_index_next;
            version_reg    <= version_next;
            padding_reg    <= padding_next;
            extension_reg  <= extension_next;
            csrc_reg       <= csrc_next;
            ext_words_reg  <= ext_words_next;
        end
    end

    assign info = '{
        valid:      in_valid_reg,
        last:       in_last_reg,
        data_byte:  in_data_reg,
        size:       size,
        version:    version_next,
        padding:    padding_next,
        extension:  extension_next,
        csrc_count: csrc_next,
        ext_words:  ext_words_next
    };

endmodule

@@ src/rphv_verdict.sv @@
module rphv_verdict import rphv_pkg::*; (
    input  hdr_info_t info,
    output verdict_t  verdict
);

    logic [6:0]  hdr_base;
    logic [18:0] hdr_full;
    logic [18:0] size_w;
    logic [15:0] payload;
    status_t     status;

    // Run the checks in priority order
    always_comb begin
        hdr_base = FIXED_HDR + {1'b0, info.csrc_count, 2'b00}
                   + (info.extension ? EXT_HDR_BYTES : 7'd0);
        hdr_full = {12'd0, hdr_base}
                   + (info.extension ? {1'b0, info.ext_words, 2'b00} : 19'd0);
        size_w   = {3'd0, info.size};
        payload  = info.size - hdr_full[15:0];
        status   = ST_OK;
        priority if (info.size < MIN_PKT_BYTES) begin
            status = ST_SHORT;
        end else if (info.version != RTP_VERSION) begin
            status = ST_BAD_VER;
        end else if (size_w < {12'd0, hdr_base}) begin
            status = ST_SHORT_HDR;
        end else if (size_w < hdr_full) begin
            status = ST_SHORT_EXT;
        end else if (info.padding) begin
            priority if (payload == 16'd0) begin
                status = ST_PAD_EMPTY;
            end else if (info.data_byte == 8'd0) begin
                status = ST_PAD_ZERO;
            end else if (payload < {8'd0, info.data_byte}) begin
                status = ST_PAD_LONG;
            end else begin
                payload = payload - {8'd0, info.data_byte};
            end
        end else begin
            status = ST_OK;
        end
        verdict.status         = status;
        verdict.payload_offset = (status == ST_OK) ? hdr_full[15:0] : 16'd0;
        verdict.payload_length = (status == ST_OK) ? payload : 16'd0;
    end

endmodule

@@ src/rtp_packet_header_validator.sv @@
// Channel  Ports                      Contents
// input    s_axis_t{valid,ready}      tdata[7:0] data_byte, tlast end_of_packet
// result   m_axis_t{valid,ready}      tdata[2:0] status, [18:3] payload_offset,
//                                     [34:19] payload_length, [39:35] zero
// One byte per clock, unless a stalled result holds a last byte: a byte is
// registered, then updates the header fields and, on the last byte, the verdict
// is written to the result register.
// Reset (aresetn low, synchronous) empties both registers and clears the
// byte counter and captured fields. A stalled result holds only the last
// byte of the next packet; other bytes keep flowing under back-pressure.
module rtp_packet_header_validator import rphv_pkg::*; #(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata    // status, payload_offset,
                                                    // payload_length, zero fill
);

    hdr_info_t   info;
    verdict_t    verdict;
    logic        advance;
    logic        load;
    logic        out_valid_reg;
    verdict_t    out_reg;

    // Process the held byte unless it ends a packet while the result is stalled
    assign advance = info.valid
                     && (!info.last || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !info.valid || advance;
    assign load = s_axis_tvalid && s_axis_tready;

    rphv_track #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_track (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (load),
        .data_byte    (s_axis_tdata[7:0]),
        .end_of_packet(s_axis_tlast),
        .advance      (advance),
        .info         (info)
    );

    rphv_verdict u_verdict (
        .info   (info),
        .verdict(verdict)
    );

    // Load a verdict on the last byte, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && info.last) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && info.last) begin
            out_reg <= verdict;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reg.payload_length, out_reg.payload_offset,
                            out_reg.status};

`ifndef SYNTH
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && out_reg.status != ST_OK
        |-> out_reg.payload_offset == 16'd0 && out_reg.payload_length == 16'd0)
        else $error("failed verdict carries nonzero offset or length");

    a_ok_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && out_reg.status == ST_OK
        |-> out_reg.payload_offset >= MIN_PKT_BYTES)
        else $error("accepted packet with header under 12 bytes");

    a_ok_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && out_reg.status == ST_OK
        |-> ({1'b0, out_reg.payload_offset} + {1'b0, out_reg.payload_length})
            <= 17'(MAX_PACKET_BYTES))
        else $error("offset plus length exceeds packet size");

    a_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !info.last && !(out_valid_reg && m_axis_tready)
        |=> m_axis_tvalid == $past(m_axis_tvalid))
        else $error("result produced by a byte that is not the last");
`endif

endmodule

@@ tb/tb_rtp_packet_header_validator.sv @@
`timescale 1ns / 100ps

module tb_rtp_packet_header_validator;
    import rphv_pkg::*;

    localparam int MAX_BYTES     = 65535;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_BYTES  = 700;
    localparam int RANDOM_PKTS   = 20;
    localparam int MAX_PRINTED   = 50;

    // Header tracker: rebuilds the verdict of each packet from its bytes
    class verdict_tracker;
        int unsigned pkt_len;
        int unsigned size_cap;
        logic [1:0]  hdr_version;
        logic        hdr_padding;
        logic        hdr_extension;
        logic [3:0]  hdr_csrc;
        logic [15:0] ext_length;
        verdict_t    expected_q[$];
        int          errors;
        int          checked;
        int          status_hits[8];

        function new(input int unsigned max_bytes);
            size_cap      = max_bytes;
            pkt_len       = 0;
            hdr_version   = '0;
            hdr_padding   = 1'b0;
            hdr_extension = 1'b0;
            hdr_csrc      = '0;
            ext_length    = '0;
            errors        = 0;
            checked       = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Capture header fields from one byte and, on the last one, queue the verdict
        function void note_byte(input logic [7:0] b, input logic last);
            int unsigned size;
            int unsigned hdr;
            int unsigned payload;
            int unsigned ext_at;
            verdict_t    v;
            if (pkt_len < size_cap) begin
                ext_at = 12 + 4 * hdr_csrc;
                if (pkt_len == 0) begin
                    hdr_version   = b[7:6];
                    hdr_padding   = b[5];
                    hdr_extension = b[4];
                    hdr_csrc      = b[3:0];
                    ext_length    = '0;
                end else if (hdr_extension) begin
                    if (pkt_len == ext_at + 2) ext_length[15:8] = b;
                    else if (pkt_len == ext_at + 3) ext_length[7:0] = b;
                end
                size = pkt_len + 1;
            end else begin
                size = size_cap;
            end
            if (!last) begin
                pkt_len = size;
                return;
            end
            pkt_len = 0;

            v.status         = ST_OK;
            v.payload_offset = '0;
            v.payload_length = '0;
            hdr = 12 + 4 * hdr_csrc + (hdr_extension ? 4 : 0);
            if (size < 12) begin
                v.status = ST_SHORT;
            end else if (hdr_version != RTP_VERSION) begin
                v.status = ST_BAD_VER;
            end else if (size < hdr) begin
                v.status = ST_SHORT_HDR;
            end else begin
                if (hdr_extension) hdr += 4 * ext_length;
                if (size < hdr) begin
                    v.status = ST_SHORT_EXT;
                end else begin
                    payload = size - hdr;
                    if (hdr_padding) begin
                        if (payload == 0) v.status = ST_PAD_EMPTY;
                        else if (b == 8'h00) v.status = ST_PAD_ZERO;
                        else if (payload < b) v.status = ST_PAD_LONG;
                        else payload -= b;
                    end
                    if (v.status == ST_OK) begin
                        v.payload_offset = hdr[15:0];
                        v.payload_length = payload[15:0];
                    end
                end
            end
            expected_q.push_back(v);
        endfunction

        task report_mismatch(input string msg);
            if (errors < MAX_PRINTED) $display("mismatch: %s", msg);
            errors++;
        endtask

        // Compare one result transaction against the oldest queued verdict
        task check_verdict(input logic [TDATA_OUT_W-1:0] word);
            verdict_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("verdict %h with no packet pending", word));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            status_hits[int'(want.status)]++;
            if (word[2:0] != want.status)
                report_mismatch($sformatf("verdict %0d: status %0d, want %0d",
                                          checked, word[2:0], want.status));
            if (word[18:3] != want.payload_offset)
                report_mismatch($sformatf("verdict %0d: offset %0d, want %0d",
                                          checked, word[18:3], want.payload_offset));
            if (word[34:19] != want.payload_length)
                report_mismatch($sformatf("verdict %0d: length %0d, want %0d",
                                          checked, word[34:19], want.payload_length));
            if (word[39:35] != '0)
                report_mismatch($sformatf("verdict %0d: fill bits %b not zero",
                                          checked, word[39:35]));
        endtask

        // Flag verdicts that never came back
        task close();
            while (expected_q.size() != 0) begin
                report_mismatch("verdict missing at end of run");
                void'(expected_q.pop_front());
            end
        endtask
    endclass

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;   // [7:0] data_byte
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;         // [2:0] status, [18:3] payload_offset,
                                                  // [34:19] payload_length, [39:35] zero

    verdict_tracker board;
    logic [7:0]     pkt_q[$];
    int             bytes_driven   = 0;
    int             packets_driven = 0;
    int             idle_cycles    = 0;
    int             ready_left     = 0;
    int unsigned    ready_roll;
    logic           sender_steady  = 1'b0;

    rtp_packet_header_validator #(
        .MAX_PACKET_BYTES(MAX_BYTES)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #4 aclk = ~aclk;

    // Randomize back-pressure: runs of ready, short stalls and the odd long one
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            ready_left    <= 0;
        end else if (ready_left == 0) begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 25) begin
                m_axis_tready <= 1'b1;
                ready_left    <= $urandom_range(20, 80);
            end else if (ready_roll < 85) begin
                m_axis_tready <= 1'b1;
                ready_left    <= $urandom_range(1, 4);
            end else if (ready_roll < 97) begin
                m_axis_tready <= 1'b0;
                ready_left    <= $urandom_range(1, 3);
            end else begin
                m_axis_tready <= 1'b0;
                ready_left    <= $urandom_range(10, 30);
            end
        end else begin
            ready_left <= ready_left - 1;
        end
    end

    // Watch both channels; stop the run if traffic dries up
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) board.check_verdict(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) board.note_byte(s_axis_tdata, s_axis_tlast);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("no transaction for %0d cycles", IDLE_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (sender_steady || roll < 60) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic void add_random(input int n);
        repeat (n) pkt_q.push_back(8'($urandom));
    endfunction

    // Fixed header plus CSRC list
    function automatic void begin_packet(input logic [1:0] ver, input logic pad,
                                         input logic ext, input logic [3:0] cc);
        pkt_q.delete();
        pkt_q.push_back({ver, pad, ext, cc});
        add_random(11 + 4 * cc);
    endfunction

    // Extension header with a length field, followed by some of its words
    function automatic void add_ext(input logic [15:0] words, input int data_words);
        add_random(2);
        pkt_q.push_back(words[15:8]);
        pkt_q.push_back(words[7:0]);
        add_random(4 * data_words);
    endfunction

    // Payload of n bytes whose final byte is given (the padding count)
    function automatic void add_payload(input int n, input logic [7:0] last_byte);
        if (n > 0) begin
            add_random(n - 1);
            pkt_q.push_back(last_byte);
        end
    endfunction

    function automatic void cut_to(input int n);
        while (pkt_q.size() > n) void'(pkt_q.pop_back());
    endfunction

    // Drive the packet in pkt_q, one byte per transaction, tlast on the final byte
    task automatic send_packet();
        int gap;
        foreach (pkt_q[i]) begin
            gap = pick_gap();
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= pkt_q[i];
            s_axis_tlast  <= (i == pkt_q.size() - 1);
            do @(posedge aclk); while (!s_axis_tready);
        end
        bytes_driven   += pkt_q.size();
        packets_driven += 1;
    endtask

    // Hold the input until every verdict in flight has been returned
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
    endtask

    task automatic send_random_packet();
        int unsigned kind;
        int unsigned roll;
        int          n;
        int          data_words;
        logic        pad;
        logic        ext;
        logic [3:0]  cc;
        logic [15:0] words;
        logic [7:0]  last_b;
        kind = $urandom_range(0, 99);
        sender_steady = ($urandom_range(0, 4) == 0);
        if (kind < 15) begin
            // noise: any first byte, any length
            pkt_q.delete();
            add_random($urandom_range(1, 40));
        end else begin
            pad = 1'($urandom);
            ext = 1'($urandom);
            cc  = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 2)) : 4'($urandom);
            begin_packet(RTP_VERSION, pad, ext, cc);
            if (ext) begin
                if ($urandom_range(0, 9) < 8) begin
                    words      = 16'($urandom_range(0, 4));
                    data_words = words;
                end else begin
                    words      = 16'($urandom);
                    data_words = $urandom_range(0, 3);
                end
                add_ext(words, data_words);
            end
            n      = $urandom_range(0, 24);
            last_b = 8'($urandom);
            if (pad && n > 0) begin
                roll = $urandom_range(0, 99);
                if (roll < 70) last_b = 8'($urandom_range(1, n));
                else if (roll < 85) last_b = 8'h00;
                else last_b = 8'($urandom_range(n + 1, 255));
            end
            add_payload(n, last_b);
            // broken sequence: packet ends anywhere
            if (kind >= 90) cut_to($urandom_range(1, pkt_q.size()));
        end
        send_packet();
    endtask

    initial begin
        int random_pkts;
        int random_start;
        board = new(MAX_BYTES);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Too short: a lone byte, then eleven bytes
        pkt_q.delete(); pkt_q.push_back(8'hFF); send_packet();
        begin_packet(RTP_VERSION, 1'b0, 1'b0, 4'd0); cut_to(11); send_packet();
        // Wrong versions
        begin_packet(2'd0, 1'b0, 1'b0, 4'd0); send_packet();
        begin_packet(2'd1, 1'b1, 1'b1, 4'd0); send_packet();
        begin_packet(2'd3, 1'b0, 1'b0, 4'd15); send_packet();
        // Minimal good header, empty payload
        begin_packet(RTP_VERSION, 1'b0, 1'b0, 4'd0); send_packet();
        // Packet ends inside the CSRC list
        begin_packet(RTP_VERSION, 1'b0, 1'b0, 4'd15); cut_to(20); send_packet();
        // Full CSRC list and zero-length extension, nothing after
        begin_packet(RTP_VERSION, 1'b0, 1'b1, 4'd15); add_ext(16'd0, 0); send_packet();
        // Packet ends before the extension length is reached
        begin_packet(RTP_VERSION, 1'b0, 1'b1, 4'd0); add_ext(16'd2, 0); cut_to(14);
        send_packet();
        // Extension data missing, small and largest length
        begin_packet(RTP_VERSION, 1'b0, 1'b1, 4'd1); add_ext(16'd3, 1); send_packet();
        begin_packet(RTP_VERSION, 1'b1, 1'b1, 4'd0); add_ext(16'hFFFF, 0); send_packet();
        // Padding checks: empty payload, zero count, count too long, count exact
        begin_packet(RTP_VERSION, 1'b1, 1'b0, 4'd0); send_packet();
        begin_packet(RTP_VERSION, 1'b1, 1'b0, 4'd2); add_payload(5, 8'h00); send_packet();
        begin_packet(RTP_VERSION, 1'b1, 1'b0, 4'd0); add_payload(5, 8'd10); send_packet();
        begin_packet(RTP_VERSION, 1'b1, 1'b0, 4'd0); add_payload(5, 8'd5); send_packet();
        begin_packet(RTP_VERSION, 1'b1, 1'b0, 4'd0); add_payload(300, 8'hFF); send_packet();
        // All flags together
        begin_packet(RTP_VERSION, 1'b1, 1'b1, 4'd3); add_ext(16'd2, 2);
        add_payload(10, 8'd4); send_packet();
        drain();

        // Random traffic, mostly well-formed packets
        random_pkts  = 0;
        random_start = bytes_driven;
        while (bytes_driven - random_start < RANDOM_BYTES || random_pkts < RANDOM_PKTS) begin
            send_random_packet();
            random_pkts++;
            if (random_pkts % 10 == 0) drain();
        end

        drain();
        repeat (20) @(posedge aclk);
        board.close();

        $display("covered %0d packets (%0d bytes), incl. truncated and noise ones",
                 packets_driven, bytes_driven);
        $display("%0d verdicts checked; per status 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 board.checked, board.status_hits[0], board.status_hits[1],
                 board.status_hits[2], board.status_hits[3], board.status_hits[4],
                 board.status_hits[5], board.status_hits[6], board.status_hits[7]);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ rtp_packet_header_validator.f @@
src/rphv_pkg.sv
src/rphv_track.sv
src/rphv_verdict.sv
src/rtp_packet_header_validator.sv
tb/tb_rtp_packet_header_validator.sv
